// File: src/sct_pkg.sv
// shared types and constants for the source character tokenizer
// depends on nothing
package sct_pkg;

  localparam int unsigned KwCount = 41;
  localparam int unsigned KwMaxLen = 11;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_IDENT, M_SLASH, M_COMMENT, M_QOPEN, M_QESC, M_QBODY,
    M_ANDOR, M_EQ, M_CMP, M_DONE
  } mode_e;

  typedef enum logic [4:0] {
    T_NUM = 5'd0, T_CHAR = 5'd1, T_PCHAR = 5'd2, T_IDENT = 5'd3, T_KEYW = 5'd4,
    T_PUNCT = 5'd5, T_MATH = 5'd6, T_LOGIC = 5'd7, T_RELOP = 5'd8,
    T_ASSIGN = 5'd9, T_ARRB = 5'd10, T_ARRE = 5'd11, T_BLKB = 5'd12,
    T_BLKE = 5'd13, T_PARO = 5'd14, T_PARC = 5'd15, T_STREAM = 5'd16,
    T_UNK = 5'd17, T_EOF = 5'd18
  } tok_type_e;

  typedef struct packed {
    logic [4:0]  token_type;
    logic [5:0]  keyword_index;
    logic [7:0]  length;
    logic [15:0] line;
    logic        last;
  } tok_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CH_RBRC  = 8'h7d;

  // keyword text, right aligned: first char in the highest used byte
  localparam logic [8*KwMaxLen-1:0] KW_TEXT [KwCount] = '{
    "atoi", "and", "bool", "block", "break", "case", "class", "char", "cin",
    "cout", "default", "else", "false", "if", "int", "itoa",
    88'h6b_78_69_32_30_31_39,
    "lock", "main", "new", "null", "object", "or", "public", "private",
    "protected", "return", "release", "string", "spawn", "sym", "set",
    "switch", "this", "true", "thread", "unprotected", "unlock", "void",
    "while", "wait"
  };

  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd4, 4'd3, 4'd4, 4'd5, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3,
    4'd4, 4'd7, 4'd4, 4'd5, 4'd2, 4'd3, 4'd4, 4'd7,
    4'd4, 4'd4, 4'd3, 4'd4, 4'd6, 4'd2, 4'd6, 4'd7,
    4'd9, 4'd6, 4'd7, 4'd6, 4'd5, 4'd3, 4'd3,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd11, 4'd6, 4'd4,
    4'd5, 4'd4
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
           || (c == 8'h5f);
  endfunction

endpackage

// File: src/sct_if.sv
// handshake channels of the tokenizer: source bytes in, tokens out
// depends on nothing
interface sct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;
  modport source (output valid, ch, at_end, input ready);
  modport sink (input valid, ch, at_end, output ready);
endinterface

interface sct_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_type;
  logic [5:0]  keyword_index;
  logic [7:0]  length;
  logic [15:0] line;
  logic        last;
  modport source (output valid, token_type, keyword_index, length, line, last,
                  input ready);
  modport sink (input valid, token_type, keyword_index, length, line, last,
                output ready);
endinterface

// File: src/source_char_tokenizer_core.sv
// source character tokenizer, top level
// depends on sct_pkg and the channels in sct_if
// a token enters the result queue when the item that ends it is accepted
// throughput: one item per cycle; an end-of-input item may add two tokens,
// which the four-entry result queue absorbs; one token leaves per cycle
// while output ready; input ready whenever the queue has room for two tokens
// reset: scanner idle, line counter one, result queue empty; the identifier
// buffer is not cleared
module source_char_tokenizer_core #(
  parameter int unsigned MAX_IDENT_LEN = 16,
  parameter int unsigned LINE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sct_in_if.sink   in_i,
  sct_out_if.source out_o
);
  import sct_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_IDENT_LEN);

  // scanner state
  mode_e                mode_q, mode_d;
  logic [4:0]           ptype_q, ptype_d;
  logic [7:0]           plen_q, plen_d;
  logic [7:0]           first_q, first_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [7:0]           ident_q [MAX_IDENT_LEN];

  // result queue
  tok_t       fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  logic acc, pop;
  assign acc = in_i.valid && in_i.ready;
  assign pop = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q <= 3'd2);

  // keyword match over the finished identifier, all words in parallel
  logic       kw_hit;
  logic [5:0] kw_idx;
  always_comb begin
    logic same;
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = KwCount - 1; k >= 0; k--) begin
      same = (plen_q == {4'd0, KW_LEN[k]});
      for (int i = 0; i < KwMaxLen; i++) begin
        if ((i < KW_LEN[k]) &&
            (ident_q[i] != KW_TEXT[k][(KW_LEN[k] - 1 - i) * 8 +: 8])) begin
          same = 1'b0;
        end
      end
      if (same) begin
        kw_hit = 1'b1;
        kw_idx = 6'(k);
      end
    end
  end

  // one pass of the scanner per accepted item
  logic [7:0] c;
  logic       absorbed, do_take, take_ident;
  logic [7:0] take_base;
  logic       fl_emit;
  tok_t       fl_tok, eof_tok, push0, push1;
  logic [1:0] npush;
  logic       st_we;
  logic [IdxW-1:0] st_idx;

  assign c = in_i.ch;

  always_comb begin
    mode_d = mode_q;
    ptype_d = ptype_q;
    plen_d = plen_q;
    first_d = first_q;
    line_d = line_q;
    absorbed = 1'b0;
    do_take = 1'b0;
    take_ident = (mode_q == M_IDENT);
    take_base = plen_q;

    // pending token as it would flush
    fl_emit = 1'b1;
    fl_tok.keyword_index = '0;
    fl_tok.length = plen_q;
    fl_tok.line = 16'(line_q);
    fl_tok.last = 1'b1;
    fl_tok.token_type = T_UNK;
    case (mode_q)
      M_NUM:   fl_tok.token_type = T_NUM;
      M_IDENT: begin
        fl_tok.token_type = kw_hit ? T_KEYW : T_IDENT;
        fl_tok.keyword_index = kw_hit ? kw_idx : 6'd0;
      end
      M_SLASH: fl_tok.token_type = T_MATH;
      M_QOPEN, M_QESC, M_QBODY: fl_tok.token_type = T_PCHAR;
      M_ANDOR: fl_tok.token_type = T_UNK;
      M_EQ:    fl_tok.token_type = T_ASSIGN;
      M_CMP:   fl_tok.token_type = (first_q == CH_BANG) ? T_UNK : T_RELOP;
      M_DONE:  fl_tok.token_type = ptype_q;
      default: fl_emit = 1'b0;
    endcase

    eof_tok.token_type = T_EOF;
    eof_tok.keyword_index = '0;
    eof_tok.length = '0;
    eof_tok.line = 16'(line_q);
    eof_tok.last = 1'b1;

    push0 = fl_tok;
    push1 = eof_tok;
    npush = 2'd0;

    if (in_i.at_end) begin
      // flush then eof
      if (fl_emit) begin
        push0.last = 1'b0;
        npush = 2'd2;
      end else begin
        push0 = eof_tok;
        npush = 2'd1;
      end
      mode_d = M_IDLE;
      plen_d = '0;
      ptype_d = '0;
    end else begin
      // try to extend the pending token
      case (mode_q)
        M_NUM: if (is_digit(c)) begin
          do_take = 1'b1; absorbed = 1'b1;
        end
        M_IDENT: if (is_digit(c) || is_alpha(c)) begin
          do_take = 1'b1; absorbed = 1'b1;
        end
        M_SLASH: if (c == CH_SLASH) begin
          mode_d = M_COMMENT; plen_d = '0; absorbed = 1'b1;
        end
        M_COMMENT: begin
          absorbed = 1'b1;
          if (c == CH_NL) begin
            mode_d = M_IDLE;
            line_d = line_q + 1'b1;
          end
        end
        M_QOPEN: begin
          if (c == CH_BSL) begin
            do_take = 1'b1; mode_d = M_QESC; absorbed = 1'b1;
          end else if (c != CH_NL) begin
            do_take = 1'b1; mode_d = M_QBODY; absorbed = 1'b1;
          end
        end
        M_QESC: if (c != CH_NL) begin
          do_take = 1'b1; mode_d = M_QBODY; absorbed = 1'b1;
        end
        M_QBODY: if (c == CH_QUOTE) begin
          do_take = 1'b1; mode_d = M_DONE; ptype_d = T_CHAR; absorbed = 1'b1;
        end
        M_ANDOR: if (c == first_q) begin
          do_take = 1'b1; mode_d = M_DONE; ptype_d = T_LOGIC; absorbed = 1'b1;
        end
        M_EQ: if (c == CH_EQ) begin
          do_take = 1'b1; mode_d = M_DONE; ptype_d = T_RELOP; absorbed = 1'b1;
        end
        M_CMP: begin
          if (c == CH_EQ) begin
            do_take = 1'b1; mode_d = M_DONE; ptype_d = T_RELOP; absorbed = 1'b1;
          end else if (((first_q == CH_LT) || (first_q == CH_GT)) &&
                       (c == first_q)) begin
            do_take = 1'b1; mode_d = M_DONE; ptype_d = T_STREAM;
            absorbed = 1'b1;
          end
        end
        default: absorbed = 1'b0;
      endcase

      if (!absorbed) begin
        // flush whatever is pending, then start on this byte
        if (fl_emit) begin
          npush = 2'd1;
          plen_d = '0;
          ptype_d = '0;
        end
        mode_d = M_IDLE;
        if (c == CH_NL) begin
          line_d = line_q + 1'b1;
        end else if ((c != CH_SP) && (c != CH_NUL)) begin
          first_d = c;
          take_base = '0;
          do_take = 1'b1;
          ptype_d = '0;
          mode_d = M_DONE;
          if (c == CH_SLASH) mode_d = M_SLASH;
          else if (is_digit(c)) mode_d = M_NUM;
          else if (is_alpha(c)) mode_d = M_IDENT;
          else if (c == CH_QUOTE) mode_d = M_QOPEN;
          else if ((c == CH_AMP) || (c == CH_PIPE)) mode_d = M_ANDOR;
          else if (c == CH_EQ) mode_d = M_EQ;
          else if ((c == CH_LT) || (c == CH_GT) || (c == CH_BANG)) mode_d = M_CMP;
          else if ((c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR))
            ptype_d = T_MATH;
          else if ((c == CH_COLON) || (c == CH_COMMA) || (c == CH_SEMI) ||
                   (c == CH_DOT)) ptype_d = T_PUNCT;
          else if (c == CH_LBRK) ptype_d = T_ARRB;
          else if (c == CH_RBRK) ptype_d = T_ARRE;
          else if (c == CH_LBRC) ptype_d = T_BLKB;
          else if (c == CH_RBRC) ptype_d = T_BLKE;
          else if (c == CH_LPAR) ptype_d = T_PARO;
          else if (c == CH_RPAR) ptype_d = T_PARC;
          else ptype_d = T_UNK;
          take_ident = (mode_d == M_IDENT);
        end
      end

      if (do_take) begin
        plen_d = (take_base == 8'hff) ? 8'hff : take_base + 8'd1;
      end
    end

    st_we = do_take && take_ident && (take_base < 8'(MAX_IDENT_LEN));
    st_idx = take_base[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      ptype_q <= '0;
      plen_q <= '0;
      first_q <= '0;
      line_q <= LINE_BITS'(1);
    end else if (acc) begin
      mode_q <= mode_d;
      ptype_q <= ptype_d;
      plen_q <= plen_d;
      first_q <= first_d;
      line_q <= line_d;
    end
  end

  // identifier buffer, written by the current identifier; bytes past its length are stale
  always_ff @(posedge clk_i) begin
    if (acc && st_we) begin
      ident_q[st_idx] <= c;
    end
  end

  // result queue
  logic [1:0] n_in;
  assign n_in = acc ? npush : 2'd0;

  always_ff @(posedge clk_i) begin
    if (n_in != 2'd0) fifo_q[wr_q] <= push0;
    if (n_in == 2'd2) fifo_q[wr_q + 2'd1] <= push1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_q + n_in;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, n_in} - {2'b00, pop};
    end
  end

  assign out_o.valid = (cnt_q != 3'd0);
  assign out_o.token_type = fifo_q[rd_q].token_type;
  assign out_o.keyword_index = fifo_q[rd_q].keyword_index;
  assign out_o.length = fifo_q[rd_q].length;
  assign out_o.line = fifo_q[rd_q].line;
  assign out_o.last = fifo_q[rd_q].last;

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");

  // end of input always leaves a token queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.at_end) |=> (cnt_q != 3'd0))
    else $error("end of input produced no token");

  // line counter moves only on accepted items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(line_q))
    else $error("line counter moved without an item");

  // after end of input the scanner is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.at_end) |=> (mode_q == M_IDLE))
    else $error("scanner not idle after end of input");

endmodule
